/* src/mtrb_pkg.sv */
// shared types, constants and helpers for the motion trail ribbon builder
`timescale 1ns / 1ps
package mtrb_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int POS_W   = 32;
    localparam int DIFF_W  = POS_W + 1;
    localparam int LEN_W   = 33;
    localparam int DIR_W   = 16;
    localparam int PATH_W  = 32;
    localparam int SEG_W   = 31;
    localparam int WID_W   = 31;
    localparam int DEPTH_W = 6;
    localparam int ACC_W   = 34;
    localparam int IDX_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [DIR_W-1:0]   DIR_ONE       = 16'd16384;
    localparam logic [SEG_W-1:0]   SEG_RESET     = 31'd65536;
    localparam logic [WID_W-1:0]   WID_RESET     = 31'd65536;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET   = 6'd32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEG   = 2'd0,
        REG_WIDTH = 2'd1,
        REG_DEPTH = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_point;

    // what a cell loads on the next edge
    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_NEXT = 2'd1,
        OP_WRAP = 2'd2,
        OP_LOAD = 2'd3
    } t_cell_op;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
        abs_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

endpackage

/* src/mtrb_in_if.sv */
// position input channel
`timescale 1ns / 1ps
interface mtrb_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

/* src/mtrb_out_if.sv */
// ribbon vertex output channel
`timescale 1ns / 1ps
interface mtrb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] dir_z;
    logic [31:0] path_length;
    logic [30:0] width_out;
    logic [4:0]  point_index;
    logic        last;
    modport source (output valid, point_x, point_y, point_z, dir_x, dir_y, dir_z,
                    path_length, width_out, point_index, last, input ready);
    modport sink   (input valid, point_x, point_y, point_z, dir_x, dir_y, dir_z,
                    path_length, width_out, point_index, last, output ready);
endinterface

/* src/mtrb_cfg_if.sv */
// configuration write channel
`timescale 1ns / 1ps
interface mtrb_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [30:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/mtrb_cell.sv */
// one trail point cell of the shift and rotate chain
`timescale 1ns / 1ps
module mtrb_cell
    import mtrb_pkg::*;
(
    input  logic     i_clk,
    input  t_cell_op i_op,
    input  t_point   i_next,
    input  t_point   i_wrap,
    input  t_point   i_load,
    output t_point   o_pt
);
    t_point r_pt;
    t_point n_pt;

    // select the source for this cell
    always_comb begin
        unique case (i_op)
            OP_HOLD: n_pt = r_pt;
            OP_NEXT: n_pt = i_next;
            OP_WRAP: n_pt = i_wrap;
            OP_LOAD: n_pt = i_load;
            default: n_pt = r_pt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pt <= n_pt;
    end

    assign o_pt = r_pt;
endmodule

/* src/mtrb_len.sv */
// segment length unit: three squares on one multiplier, then bit-serial square root
`timescale 1ns / 1ps
module mtrb_len
    import mtrb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIFF_W-1:0] i_dx,
    input  logic signed [DIFF_W-1:0] i_dy,
    input  logic signed [DIFF_W-1:0] i_dz,
    output logic                     o_done,
    output logic [LEN_W-1:0]         o_len
);
    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_SQ   = 3'b010,
        L_RT   = 3'b100
    } t_len_state;

    t_len_state r_state;
    logic        r_done;
    logic [LEN_W-1:0] r_len;
    logic [31:0] r_op0, r_op1, r_op2;
    logic        r_k;
    logic [1:0]  r_cnt;
    logic [63:0] r_prod;
    logic [63:0] r_sum;
    logic [63:0] r_rad;
    logic [35:0] r_rem;
    logic [31:0] r_res;
    logic [4:0]  r_step;

    logic [DIFF_W-1:0] ax, ay, az;
    logic        k;
    logic [31:0] op_sel;
    logic [63:0] sq;
    logic [35:0] rem_sh, trial, n_rem;
    logic [31:0] n_res;

    // magnitudes, halved when any reaches 2^31
    always_comb begin
        ax = abs_diff(i_dx);
        ay = abs_diff(i_dy);
        az = abs_diff(i_dz);
        k  = (|ax[32:31]) | (|ay[32:31]) | (|az[32:31]);
    end

    // squaring, one component a cycle
    always_comb begin
        unique case (r_cnt)
            2'd0:    op_sel = r_op0;
            2'd1:    op_sel = r_op1;
            default: op_sel = r_op2;
        endcase
        sq = 64'(op_sel) * 64'(op_sel);
    end

    // one root digit per cycle
    always_comb begin
        rem_sh = {r_rem[33:0], r_rad[63:62]};
        trial  = {2'b00, r_res, 2'b01};
        if (rem_sh >= trial) begin
            n_rem = rem_sh - trial;
            n_res = {r_res[30:0], 1'b1};
        end else begin
            n_rem = rem_sh;
            n_res = {r_res[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_op0   <= k ? ax[32:1] : ax[31:0];
                        r_op1   <= k ? ay[32:1] : ay[31:0];
                        r_op2   <= k ? az[32:1] : az[31:0];
                        r_k     <= k;
                        r_cnt   <= 2'd0;
                        r_sum   <= '0;
                        r_state <= L_SQ;
                    end
                end
                L_SQ: begin
                    r_prod <= sq;
                    if (r_cnt != 2'd0) begin
                        r_sum <= r_sum + r_prod;
                    end
                    if (r_cnt == 2'd3) begin
                        r_rad   <= r_sum + r_prod;
                        r_rem   <= '0;
                        r_res   <= '0;
                        r_step  <= '0;
                        r_state <= L_RT;
                    end
                    r_cnt <= r_cnt + 2'd1;
                end
                L_RT: begin
                    r_rem  <= n_rem;
                    r_res  <= n_res;
                    r_rad  <= {r_rad[61:0], 2'b00};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_len   <= r_k ? {n_res, 1'b0} : {1'b0, n_res};
                        r_done  <= 1'b1;
                        r_state <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_len  = r_len;
endmodule

/* src/mtrb_div.sv */
// direction unit: three restoring dividers sharing the segment length
`timescale 1ns / 1ps
module mtrb_div
    import mtrb_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [2:0][DIFF_W-1:0]       i_a,
    input  logic [2:0]                   i_neg,
    input  logic [LEN_W-1:0]             i_len,
    output logic                         o_done,
    output logic [2:0][DIR_W-1:0]        o_dir
);
    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_RUN  = 2'b10
    } t_div_state;

    t_div_state r_state;
    logic       r_done;
    logic [3:0] r_cnt;
    logic [LEN_W-1:0] r_len;
    logic [2:0] r_neg;
    logic [2:0][LEN_W+1:0] r_rem;
    logic [2:0][15:0] r_lo;
    logic [2:0][15:0] r_q;
    logic [2:0][DIR_W-1:0] r_dir;

    logic [2:0][47:0] num;
    logic [2:0][LEN_W+1:0] rsh, n_rem;
    logic [2:0][15:0] n_q, clamp;

    // numerator with rounding term, and one quotient bit per lane
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            num[j] = 48'({i_a[j], 14'b0}) + 48'(i_len[LEN_W-1:1]);
            rsh[j] = {r_rem[j][LEN_W:0], r_lo[j][15]};
            if (rsh[j] >= {2'b00, r_len}) begin
                n_rem[j] = rsh[j] - {2'b00, r_len};
                n_q[j]   = {r_q[j][14:0], 1'b1};
            end else begin
                n_rem[j] = rsh[j];
                n_q[j]   = {r_q[j][14:0], 1'b0};
            end
            clamp[j] = (n_q[j] > DIR_ONE) ? DIR_ONE : n_q[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        for (int j = 0; j < 3; j++) begin
                            r_rem[j] <= (LEN_W+2)'(num[j][47:16]);
                            r_lo[j]  <= num[j][15:0];
                            r_q[j]   <= '0;
                        end
                        r_len   <= i_len;
                        r_neg   <= i_neg;
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    for (int j = 0; j < 3; j++) begin
                        r_rem[j] <= n_rem[j];
                        r_q[j]   <= n_q[j];
                        r_lo[j]  <= {r_lo[j][14:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        for (int j = 0; j < 3; j++) begin
                            if (r_len == '0) begin
                                r_dir[j] <= '0;
                            end else if (r_neg[j]) begin
                                r_dir[j] <= DIR_W'(-clamp[j]);
                            end else begin
                                r_dir[j] <= clamp[j];
                            end
                        end
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_dir  = r_dir;
endmodule

/* src/motion_trail_ribbon_builder_unit.sv */
// motion trail ribbon builder top level: sequencer, trail cell chain and arithmetic units
//
//  channel   dir   handshake           word
//  i_in      in    valid/ready         pos_x, pos_y, pos_z
//  o_out     out   valid/ready         point, dir, path_length, width_out, index, last
//  i_cfg     in    valid/ready         index, data (ready always high)
//
// one item at a time: after acceptance the new position is measured against the newest
// held point, if any, by the length unit; the sequencer then decides and records it, with
// one drop state per dropped point; then each held point takes the squares and the
// bit-serial square root, the dividers and the sequencing states.
// synchronous active-low reset clears control state; trail cells need no clearing.
// a stalled output holds the sequencer in its store state; input is taken again once
// the last word of the current item sits in the output register.
`timescale 1ns / 1ps
module motion_trail_ribbon_builder_unit
    import mtrb_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mtrb_in_if.sink    i_in,
    mtrb_out_if.source o_out,
    mtrb_cfg_if.sink   i_cfg
);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int EW = (CW > DEPTH_W) ? CW : DEPTH_W;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_MEAS   = 11'b00000000010,
        S_MWAIT  = 11'b00000000100,
        S_DECIDE = 11'b00000001000,
        S_DROP   = 11'b00000010000,
        S_APPEND = 11'b00000100000,
        S_SEG    = 11'b00001000000,
        S_SWAIT  = 11'b00010000000,
        S_DIV    = 11'b00100000000,
        S_DWAIT  = 11'b01000000000,
        S_STORE  = 11'b10000000000
    } t_state;

    t_state r_state;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_i;
    logic signed [ACC_W-1:0] r_acc;
    logic [SEG_W-1:0]   r_seg;
    logic [WID_W-1:0]   r_width;
    logic [DEPTH_W-1:0] r_depth;
    t_point r_pos, r_new, r_prev;
    logic [LEN_W-1:0]  r_len;
    logic [PATH_W-1:0] r_path;

    // output register
    logic r_ov;
    t_point r_opt;
    logic [2:0][DIR_W-1:0] r_odir;
    logic [PATH_W-1:0] r_opath;
    logic [WID_W-1:0]  r_owidth;
    logic [IDX_W-1:0]  r_oidx;
    logic r_olast;

    t_point   w_cell [MAX_POINTS];
    t_cell_op w_op   [MAX_POINTS];

    logic in_fire, store_fire;
    logic [CW-1:0] cnt_m1, depth_eff;
    logic [EW-1:0] depth_ext;
    t_point seg_a, seg_b;
    logic signed [DIFF_W-1:0] sdx, sdy, sdz, mdx, mdy, mdz;
    logic len_start, len_done, div_start, div_done;
    logic [LEN_W-1:0] len_val;
    logic [2:0][DIFF_W-1:0] div_a;
    logic [2:0] div_neg;
    logic [2:0][DIR_W-1:0] div_dir;
    logic append_now;
    logic signed [ACC_W+1:0] acc_sum;
    logic [PATH_W+1:0] path_sum;

    function automatic logic signed [ACC_W-1:0] acc_sat(input logic signed [ACC_W+1:0] v);
        logic signed [ACC_W+1:0] hi, lo;
        hi = (ACC_W+2)'({1'b0, {(ACC_W-1){1'b1}}});
        lo = -hi - (ACC_W+2)'(1);
        if (v > hi) begin
            acc_sat = ACC_W'(hi);
        end else if (v < lo) begin
            acc_sat = ACC_W'(lo);
        end else begin
            acc_sat = ACC_W'(v);
        end
    endfunction

    assign in_fire    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign store_fire = (r_state == S_STORE) && (!r_ov || o_out.ready);
    assign cnt_m1     = r_count - CW'(1);

    // effective depth clamped to 2 .. MAX_POINTS
    always_comb begin
        depth_ext = EW'(r_depth);
        if (depth_ext < EW'(2)) begin
            depth_eff = CW'(2);
        end else if (depth_ext > EW'(MAX_POINTS)) begin
            depth_eff = CW'(MAX_POINTS);
        end else begin
            depth_eff = CW'(depth_ext);
        end
    end

    // segment endpoints: oldest point uses the segment to its successor
    always_comb begin
        seg_a = (r_i == '0) ? w_cell[0] : r_prev;
        seg_b = (r_i == '0) ? w_cell[1] : w_cell[0];
        sdx = DIFF_W'(seg_b.x) - DIFF_W'(seg_a.x);
        sdy = DIFF_W'(seg_b.y) - DIFF_W'(seg_a.y);
        sdz = DIFF_W'(seg_b.z) - DIFF_W'(seg_a.z);
        mdx = DIFF_W'(r_new.x) - DIFF_W'(r_pos.x);
        mdy = DIFF_W'(r_new.y) - DIFF_W'(r_pos.y);
        mdz = DIFF_W'(r_new.z) - DIFF_W'(r_pos.z);
        div_a[0] = abs_diff(sdx);
        div_a[1] = abs_diff(sdy);
        div_a[2] = abs_diff(sdz);
        div_neg  = {sdz[DIFF_W-1], sdy[DIFF_W-1], sdx[DIFF_W-1]};
    end

    assign len_start = (r_state == S_MEAS) || (r_state == S_SEG);
    assign div_start = (r_state == S_DIV);

    mtrb_len u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (len_start),
        .i_dx    ((r_state == S_MEAS) ? mdx : sdx),
        .i_dy    ((r_state == S_MEAS) ? mdy : sdy),
        .i_dz    ((r_state == S_MEAS) ? mdz : sdz),
        .o_done  (len_done),
        .o_len   (len_val)
    );

    mtrb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (div_a),
        .i_neg   (div_neg),
        .i_len   (r_len),
        .o_done  (div_done),
        .o_dir   (div_dir)
    );

    // cell controls: overwrite newest, drop oldest, append, rotate on emit
    always_comb begin
        for (int j = 0; j < MAX_POINTS; j++) begin
            w_op[j] = OP_HOLD;
            if (r_state == S_MWAIT && len_done && CW'(j) == cnt_m1) begin
                w_op[j] = OP_LOAD;
            end else if (r_state == S_DROP) begin
                w_op[j] = OP_NEXT;
            end else if (r_state == S_APPEND && CW'(j) == r_count) begin
                w_op[j] = OP_LOAD;
            end else if (store_fire && CW'(j) < cnt_m1) begin
                w_op[j] = OP_NEXT;
            end else if (store_fire && CW'(j) == cnt_m1) begin
                w_op[j] = OP_WRAP;
            end
        end
    end

    // trail chain, oldest point in cell 0
    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        if (g < MAX_POINTS - 1) begin : g_mid
            mtrb_cell u_cell (
                .i_clk  (i_clk),
                .i_op   (w_op[g]),
                .i_next (w_cell[g+1]),
                .i_wrap (w_cell[0]),
                .i_load (r_pos),
                .o_pt   (w_cell[g])
            );
        end else begin : g_end
            mtrb_cell u_cell (
                .i_clk  (i_clk),
                .i_op   (w_op[g]),
                .i_next (w_cell[0]),
                .i_wrap (w_cell[0]),
                .i_load (r_pos),
                .o_pt   (w_cell[g])
            );
        end
    end

    assign append_now = (r_acc > $signed({3'b000, r_seg})) || (r_count == '0);
    assign acc_sum    = (ACC_W+2)'(r_acc) + $signed({2'b00, len_val});
    assign path_sum   = (PATH_W+2)'(r_path) + (PATH_W+2)'(len_val);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg   <= SEG_RESET;
            r_width <= WID_RESET;
            r_depth <= DEPTH_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SEG:   r_seg   <= i_cfg.data[SEG_W-1:0];
                REG_WIDTH: r_width <= i_cfg.data[WID_W-1:0];
                REG_DEPTH: r_depth <= i_cfg.data[DEPTH_W-1:0];
                default:   ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_acc   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_pos   <= '{x: i_in.pos_x, y: i_in.pos_y, z: i_in.pos_z};
                        r_state <= (r_count == '0) ? S_DECIDE : S_MEAS;
                    end
                end
                S_MEAS: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (len_done) begin
                        r_acc   <= acc_sat(acc_sum);
                        r_new   <= r_pos;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (append_now) begin
                        r_state <= (r_count >= depth_eff) ? S_DROP : S_APPEND;
                    end else if (r_count >= CW'(2)) begin
                        r_i     <= '0;
                        r_path  <= '0;
                        r_state <= S_SEG;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DROP: begin
                    r_count <= cnt_m1;
                    r_state <= S_DECIDE;
                end
                S_APPEND: begin
                    r_count <= r_count + CW'(1);
                    r_new   <= r_pos;
                    r_acc   <= acc_sat((ACC_W+2)'(r_acc) - (ACC_W+2)'(r_seg));
                    r_i     <= '0;
                    r_path  <= '0;
                    r_state <= (r_count >= CW'(1)) ? S_SEG : S_IDLE;
                end
                S_SEG: r_state <= S_SWAIT;
                S_SWAIT: begin
                    if (len_done) begin
                        r_len <= len_val;
                        if (r_i != '0) begin
                            r_path <= (|path_sum[PATH_W+1:PATH_W]) ? '1 : path_sum[PATH_W-1:0];
                        end
                        r_state <= S_DIV;
                    end
                end
                S_DIV: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (div_done) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    if (store_fire) begin
                        r_ov     <= 1'b1;
                        r_opt    <= w_cell[0];
                        r_odir   <= div_dir;
                        r_opath  <= r_path;
                        r_owidth <= r_width;
                        r_oidx   <= IDX_W'(r_i);
                        r_olast  <= (r_i == cnt_m1);
                        r_prev   <= w_cell[0];
                        r_i      <= r_i + CW'(1);
                        r_state  <= (r_i == cnt_m1) ? S_IDLE : S_SEG;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output port
    assign o_out.valid       = r_ov;
    assign o_out.point_x     = r_opt.x;
    assign o_out.point_y     = r_opt.y;
    assign o_out.point_z     = r_opt.z;
    assign o_out.dir_x       = r_odir[0];
    assign o_out.dir_y       = r_odir[1];
    assign o_out.dir_z       = r_odir[2];
    assign o_out.path_length = r_opath;
    assign o_out.width_out   = r_owidth;
    assign o_out.point_index = r_oidx;
    assign o_out.last        = r_olast;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("trail point count above capacity");

    a_drop_needs_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DROP |-> r_count >= CW'(2))
        else $error("drop with fewer than two points");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state != S_IDLE)
        else $error("accepted word did not start work");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_fire |-> r_i < r_count && r_count >= CW'(2))
        else $error("emitted point outside held trail");
endmodule

/* tb/sv/mtrb_trail_checker.sv */
// trail checker: watches the channels, predicts ribbon vertices and compares them
`timescale 1ns / 1ps
module mtrb_trail_checker
    import mtrb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mtrb_in_if.sink   in_mon,
    mtrb_out_if.sink  out_mon,
    mtrb_cfg_if.sink  cfg_mon,
    output int        o_errors,
    output int        o_pending
);
    localparam int DEPTH_MAX = 32;
    localparam longint ACC_HI = 64'sd8589934591;
    localparam longint ACC_LO = -64'sd8589934592;

    typedef struct packed {
        logic [31:0] px, py, pz;
        logic [15:0] dx, dy, dz;
        logic [31:0] path;
        logic [30:0] wid;
        logic [4:0]  idx;
        logic        lst;
    } t_vertex;

    t_vertex vertex_q[$];
    longint  tx[DEPTH_MAX], ty[DEPTH_MAX], tz[DEPTH_MAX];
    int      head_ptr, held;
    longint  moved;
    logic [30:0] seg_dist, rib_width;
    logic [5:0]  depth_reg;

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint unsigned span(longint dx, longint dy, longint dz);
        longint unsigned ax, ay, az, m;
        int k;
        ax = mag(dx); ay = mag(dy); az = mag(dz);
        m = ax; k = 0;
        if (ay > m) m = ay;
        if (az > m) m = az;
        if (m >= 64'h8000_0000) begin
            k = 1; ax >>= 1; ay >>= 1; az >>= 1;
        end
        return sqrt_floor(ax * ax + ay * ay + az * az) << k;
    endfunction

    function automatic logic [15:0] unit_comp(longint d, longint unsigned len);
        longint unsigned q;
        if (len == 0) return '0;
        q = (mag(d) * 64'd16384 + (len >> 1)) / len;
        if (q > 16384) q = 16384;
        return d < 0 ? 16'(-q) : 16'(q);
    endfunction

    function automatic longint clip_acc(longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    // advance the trail by one frame and queue the vertices it yields
    task automatic track_frame(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z);
        int n, dep, drop, cur, a, b;
        longint ddx, ddy, ddz;
        longint unsigned len, path;
        t_vertex v;
        path = 0;
        if (held > 0) begin
            n = (head_ptr + held - 1) % DEPTH_MAX;
            len = span(tx[n] - x, ty[n] - y, tz[n] - z);
            tx[n] = x; ty[n] = y; tz[n] = z;
            moved = clip_acc(moved + longint'(len));
        end
        if (moved > longint'(seg_dist) || held == 0) begin
            dep = depth_reg < 2 ? 2 : (depth_reg > DEPTH_MAX ? DEPTH_MAX : depth_reg);
            if (held >= dep) begin
                drop = held - dep + 1;
                head_ptr = (head_ptr + drop) % DEPTH_MAX;
                held -= drop;
            end
            n = (head_ptr + held) % DEPTH_MAX;
            tx[n] = x; ty[n] = y; tz[n] = z;
            held++;
            moved = clip_acc(moved - longint'(seg_dist));
        end
        if (held < 2) return;
        for (int i = 0; i < held; i++) begin
            cur = (head_ptr + i) % DEPTH_MAX;
            a = (i == 0) ? cur : (head_ptr + i - 1) % DEPTH_MAX;
            b = (i == 0) ? (head_ptr + 1) % DEPTH_MAX : cur;
            ddx = tx[b] - tx[a]; ddy = ty[b] - ty[a]; ddz = tz[b] - tz[a];
            len = span(ddx, ddy, ddz);
            if (i > 0) begin
                path += len;
                if (path > 64'hFFFF_FFFF) path = 64'hFFFF_FFFF;
            end
            v.px = tx[cur][31:0]; v.py = ty[cur][31:0]; v.pz = tz[cur][31:0];
            v.dx = unit_comp(ddx, len);
            v.dy = unit_comp(ddy, len);
            v.dz = unit_comp(ddz, len);
            v.path = path[31:0];
            v.wid = rib_width;
            v.idx = 5'(i);
            v.lst = (i + 1 == held);
            vertex_q = {vertex_q, v};
        end
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        o_errors++;
    endtask

    // compare one delivered vertex with the oldest prediction
    task automatic check_vertex();
        t_vertex w;
        if (vertex_q.size() == 0) begin
            report("unexpected word", 0, 0);
            return;
        end
        w = vertex_q.pop_front();
        if (out_mon.point_x != w.px) report("point_x", out_mon.point_x, w.px);
        if (out_mon.point_y != w.py) report("point_y", out_mon.point_y, w.py);
        if (out_mon.point_z != w.pz) report("point_z", out_mon.point_z, w.pz);
        if (out_mon.dir_x != w.dx) report("dir_x", out_mon.dir_x, w.dx);
        if (out_mon.dir_y != w.dy) report("dir_y", out_mon.dir_y, w.dy);
        if (out_mon.dir_z != w.dz) report("dir_z", out_mon.dir_z, w.dz);
        if (out_mon.path_length != w.path) report("path_length", out_mon.path_length, w.path);
        if (out_mon.width_out != w.wid) report("width_out", out_mon.width_out, w.wid);
        if (out_mon.point_index != w.idx) report("point_index", out_mon.point_index, w.idx);
        if (out_mon.last != w.lst) report("last", out_mon.last, w.lst);
    endtask

    // sample all channels at the edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_ptr  = 0;
            held      = 0;
            moved     = 0;
            seg_dist  = SEG_RESET;
            rib_width = WID_RESET;
            depth_reg = DEPTH_RESET;
        end else begin
            if (out_mon.valid && out_mon.ready) check_vertex();
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (t_reg_idx'(cfg_mon.index))
                    REG_SEG:   seg_dist = cfg_mon.data;
                    REG_WIDTH: rib_width = cfg_mon.data;
                    REG_DEPTH: depth_reg = cfg_mon.data[5:0];
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
                track_frame(in_mon.pos_x, in_mon.pos_y, in_mon.pos_z);
        end
        o_pending = vertex_q.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end
endmodule

/* tb/sv/motion_trail_ribbon_builder_unit_test.sv */
// testbench top: stimulus, idling phases and verdict for the ribbon builder
`timescale 1ns / 1ps
module motion_trail_ribbon_builder_unit_test
    import mtrb_pkg::*;
;

    localparam longint LIMIT = 64'd3_000_000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    int     errors, pending;
    longint cycle_cnt = 0;
    int     send_idle = 0, recv_stall = 0;
    bit     hold_recv = 1'b0;

    mtrb_in_if  pos_ch ();
    mtrb_out_if vtx_ch ();
    mtrb_cfg_if cfg_ch ();

    motion_trail_ribbon_builder_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (pos_ch.sink),
        .o_out  (vtx_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    mtrb_trail_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .in_mon   (pos_ch.sink),
        .out_mon  (vtx_ch.sink),
        .cfg_mon  (cfg_ch.sink),
        .o_errors (errors),
        .o_pending(pending)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver ready with random stalls or a long hold-off
    always @(posedge i_clk) begin
        if (hold_recv) vtx_ch.ready <= 1'b0;
        else vtx_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    initial begin
        vtx_ch.ready = 1'b0;
        pos_ch.valid = 1'b0;
        pos_ch.pos_x = '0;
        pos_ch.pos_y = '0;
        pos_ch.pos_z = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
    end

    // one position word, with random idle before it
    task automatic send_pos(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < send_idle) @(posedge i_clk);
        pos_ch.valid <= 1'b1;
        pos_ch.pos_x <= x;
        pos_ch.pos_y <= y;
        pos_ch.pos_z <= z;
        @(posedge i_clk);
        while (!pos_ch.ready) @(posedge i_clk);
        pos_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait out every expected word plus trailing latency
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (2200) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx r, logic [30:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= d;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random walk step of chosen scale
    task automatic walk(int n, int scale_sh);
        logic signed [31:0] x, y, z;
        x = $urandom; y = $urandom; z = $urandom;
        repeat (n) begin
            if ($urandom_range(9) == 0) begin
                x = $urandom; y = $urandom; z = $urandom;
            end else begin
                x += $signed($urandom) >>> scale_sh;
                y += $signed($urandom) >>> scale_sh;
                z += $signed($urandom) >>> scale_sh;
            end
            send_pos(x, y, z);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, repeated point, tiny steps, huge jumps
        send_pos(32'h0, 32'h0, 32'h0);
        send_pos(32'h0, 32'h0, 32'h0);
        send_pos(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_pos(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_pos(32'h0001_0000, 32'h0, 32'hFFFF_FFFF);
        send_pos(32'h0001_0001, 32'h0, 32'hFFFF_FFFF);
        send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();
        // shallow depth below two, huge spacing and maximum width
        write_reg(REG_DEPTH, 31'd0);
        write_reg(REG_SEG, 31'h7FFF_FFFF);
        write_reg(REG_WIDTH, 31'h7FFF_FFFF);
        walk(6, 0);
        drain();
        // depth over the maximum, minimal spacing, zero width
        write_reg(REG_DEPTH, 31'h3F);
        write_reg(REG_SEG, 31'd1);
        write_reg(REG_WIDTH, 31'd0);
        walk(8, 4);
        drain();
        // lower depth below the held count
        write_reg(REG_DEPTH, 31'd3);
        walk(4, 6);
        drain();

        // random phases across idling modes
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_DEPTH, 31'($urandom_range(2, ph < 4 ? 8 : 40)));
            write_reg(REG_SEG, 31'($urandom_range(1, 32'h0008_0000)));
            write_reg(REG_WIDTH, 31'($urandom));
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 73; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 73; end
                default: begin send_idle = 9; recv_stall = 9; end
            endcase
            if (ph == 5) begin
                // long receiver hold-off while inputs keep coming
                fork
                    begin
                        hold_recv = 1'b1;
                        repeat (6000) @(posedge i_clk);
                        hold_recv = 1'b0;
                    end
                    walk(18, 10);
                join
            end else begin
                walk(18, ph < 4 ? 12 : 8);
            end
            drain();
        end

        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
